// ===== design/abd_pkg.sv =====
// ----------------------------------------------------------------------------
// abd_pkg
// Shared types, constants and coefficient tables of the ADPCM block decoder.
// ----------------------------------------------------------------------------
package abd_pkg;

    localparam int SAMPLES_PER_BLOCK = 28;
    // byte position of the last data byte of a block
    localparam int LAST_BYTE_POS     = 1 + SAMPLES_PER_BLOCK / 2;
    localparam int QUEUE_DEPTH       = 2;
    localparam int MAX_FILTER        = 4;

    localparam logic signed [15:0] SAMPLE_MAX = 16'sd32767;
    localparam logic signed [15:0] SAMPLE_MIN = -16'sd32767;

    // command handed from the front to the back
    typedef struct packed {
        logic       is_clear;   // restart: clear history, no samples
        logic [7:0] data;       // two nibbles, low first
        logic [3:0] shift;
        logic [2:0] filter;
        logic       last;       // last data byte of the block
        logic       f_loop;     // flags bit 2
        logic       f_stop;     // flags bit 0 and flags != 3
        logic       f_rep;      // flags == 3
    } t_cmd;

    function automatic logic signed [7:0] coef_a(input logic [2:0] f);
        logic signed [7:0] c;
        case (f)
            3'd0:    c = 8'sd0;
            3'd1:    c = 8'sd60;
            3'd2:    c = 8'sd115;
            3'd3:    c = 8'sd98;
            default: c = 8'sd122;
        endcase
        return c;
    endfunction

    function automatic logic signed [7:0] coef_b(input logic [2:0] f);
        logic signed [7:0] c;
        case (f)
            3'd0:    c = 8'sd0;
            3'd1:    c = 8'sd0;
            3'd2:    c = -8'sd52;
            3'd3:    c = -8'sd55;
            default: c = -8'sd60;
        endcase
        return c;
    endfunction

endpackage

// ===== design/abd_if.sv =====
// ----------------------------------------------------------------------------
// abd_in_if / abd_out_if
// Valid/ready channels of the ADPCM block decoder: byte input, sample output.
// ----------------------------------------------------------------------------
interface abd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface abd_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               block_last;
    logic               loop_start;
    logic               stop_after;
    logic               loop_repeat;

    modport source (output valid, output sample, output block_last, output loop_start,
                    output stop_after, output loop_repeat, input ready);
    modport sink   (input valid, input sample, input block_last, input loop_start,
                    input stop_after, input loop_repeat, output ready);
endinterface

// ===== design/abd_front.sv =====
// ----------------------------------------------------------------------------
// abd_front
// Accepts stream bytes, tracks the block position, captures header and flags,
// and queues data bytes and restarts for the sample datapath.
// ----------------------------------------------------------------------------
module abd_front
    import abd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    abd_in_if.sink     i_in,
    output logic       o_push_valid,
    input  logic       i_push_ready,
    output t_cmd       o_push_cmd
);

    logic [3:0] r_pos;
    logic [3:0] r_shift;
    logic [2:0] r_filter;
    logic [7:0] r_flags;
    logic [3:0] w_pos;
    logic       w_accept;
    logic       w_last;

    assign i_in.ready = i_push_ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_pos      = i_in.restart ? 4'd0 : r_pos;
    assign w_last     = (w_pos >= 4'(LAST_BYTE_POS));

    // header and flag bytes queue nothing unless a restart must clear history
    assign o_push_valid = i_in.valid && (i_in.restart || (w_pos >= 4'd2));

    always_comb begin
        o_push_cmd          = '0;
        o_push_cmd.is_clear = i_in.restart;
        o_push_cmd.data     = i_in.data_byte;
        o_push_cmd.shift    = r_shift;
        o_push_cmd.filter   = r_filter;
        o_push_cmd.last     = w_last;
        o_push_cmd.f_loop   = r_flags[2];
        o_push_cmd.f_stop   = r_flags[0] && (r_flags != 8'd3);
        o_push_cmd.f_rep    = (r_flags == 8'd3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_shift  <= '0;
            r_filter <= '0;
            r_flags  <= '0;
        end else if (w_accept) begin
            case (w_pos)
                4'd0: begin
                    r_shift  <= i_in.data_byte[3:0];
                    r_filter <= (i_in.data_byte[7:4] > 4'(MAX_FILTER))
                                ? 3'(MAX_FILTER) : i_in.data_byte[6:4];
                    r_pos    <= 4'd1;
                end
                4'd1: begin
                    r_flags <= i_in.data_byte;
                    r_pos   <= 4'd2;
                end
                default: begin
                    r_pos <= w_last ? 4'd0 : w_pos + 4'd1;
                end
            endcase
        end
    end

endmodule

// ===== design/abd_fifo.sv =====
// ----------------------------------------------------------------------------
// abd_fifo
// Small command queue between the front and the sample datapath.
// ----------------------------------------------------------------------------
module abd_fifo
    import abd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_cmd,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_push;
    logic          w_pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/abd_back.sv =====
// ----------------------------------------------------------------------------
// abd_back
// Sample datapath: per nibble a multiply state and an add/saturate state,
// two-sample history, and the output register.
// ----------------------------------------------------------------------------
module abd_back
    import abd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_ignore_loop,
    input  logic       i_pop_valid,
    output logic       o_pop_ready,
    input  t_cmd       i_pop_cmd,
    abd_out_if.source  o_out
);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_ADD} t_state;

    t_state             r_state;
    t_cmd               r_cmd;
    logic               r_half;
    logic signed [15:0] r_h1;
    logic signed [15:0] r_h2;
    logic signed [15:0] r_term;
    logic signed [23:0] r_pa;
    logic signed [23:0] r_pb;
    logic               r_out_valid;
    logic signed [15:0] r_sample;
    logic               r_block_last;
    logic               r_loop_start;
    logic               r_stop_after;
    logic               r_loop_repeat;

    logic [3:0]         w_nib;
    logic signed [15:0] w_term;
    logic signed [23:0] w_pa;
    logic signed [23:0] w_pb;
    logic signed [19:0] w_sum;
    logic signed [15:0] w_sat;
    logic               w_out_free;
    logic               w_end;
    logic               w_emit;

    assign o_pop_ready = (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_end       = r_half && r_cmd.last;
    assign w_emit      = (r_state == S_ADD) && w_out_free;

    always_comb begin
        w_nib  = r_half ? r_cmd.data[7:4] : r_cmd.data[3:0];
        w_term = $signed({w_nib, 12'b0}) >>> r_cmd.shift;
        w_pa   = r_h1 * coef_a(r_cmd.filter);
        w_pb   = r_h2 * coef_b(r_cmd.filter);
        // products floor-shifted by 6; sum stays well inside 20 bits
        w_sum  = 20'(r_term) + 20'(r_pa >>> 6) + 20'(r_pb >>> 6);
        if (w_sum > 20'(SAMPLE_MAX)) begin
            w_sat = SAMPLE_MAX;
        end else if (w_sum < 20'(SAMPLE_MIN)) begin
            w_sat = SAMPLE_MIN;
        end else begin
            w_sat = w_sum[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_half      <= 1'b0;
            r_h1        <= '0;
            r_h2        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_emit || (r_out_valid && !o_out.ready);
            case (r_state)
                S_IDLE: begin
                    if (i_pop_valid) begin
                        r_cmd  <= i_pop_cmd;
                        r_half <= 1'b0;
                        if (i_pop_cmd.is_clear) begin
                            r_h1 <= '0;
                            r_h2 <= '0;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_term  <= w_term;
                    r_pa    <= w_pa;
                    r_pb    <= w_pb;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (w_out_free) begin
                        r_sample      <= w_sat;
                        r_block_last  <= w_end;
                        r_loop_start  <= w_end && r_cmd.f_loop && !i_ignore_loop;
                        r_stop_after  <= w_end && r_cmd.f_stop;
                        r_loop_repeat <= w_end && r_cmd.f_rep;
                        r_h2          <= r_h1;
                        r_h1          <= w_sat;
                        r_half        <= 1'b1;
                        r_state       <= r_half ? S_IDLE : S_MUL;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.sample      = r_sample;
    assign o_out.block_last  = r_block_last;
    assign o_out.loop_start  = r_loop_start;
    assign o_out.stop_after  = r_stop_after;
    assign o_out.loop_repeat = r_loop_repeat;

endmodule

// ===== design/adpcm_block_decoder_top.sv =====
// ----------------------------------------------------------------------------
// adpcm_block_decoder_top
// Decoder for 16-byte sound-memory ADPCM blocks, two samples per data byte.
// ----------------------------------------------------------------------------
// Header and flag bytes are taken by the front while the command queue has
// room. A data byte occupies the sample datapath for a pop, then a multiply
// state and an add/saturate state for each of its two nibbles (add/saturate
// waits while the output register is full); the 16x8 coefficient multiply and
// the history dependency between the two nibbles set these steps. A command
// queue of QUEUE_DEPTH entries lets the front keep accepting bytes while the
// datapath works, and an output register holds a finished sample until it is
// taken. The user writes ignore_loop through i_cfg_wr_en/i_cfg_wr_data only
// while the block is idle; the block itself does not enforce this.
module adpcm_block_decoder_top
    import abd_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    abd_in_if.sink     i_in,
    abd_out_if.source  o_out
);

    logic r_ignore_loop;
    logic w_push_valid;
    logic w_push_ready;
    t_cmd w_push_cmd;
    logic w_pop_valid;
    logic w_pop_ready;
    t_cmd w_pop_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ignore_loop <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_ignore_loop <= i_cfg_wr_data;
        end
    end

    abd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_cmd   (w_push_cmd)
    );

    abd_fifo #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_cmd   (w_push_cmd),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_cmd    (w_pop_cmd)
    );

    abd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ignore_loop (r_ignore_loop),
        .i_pop_valid   (w_pop_valid),
        .o_pop_ready   (w_pop_ready),
        .i_pop_cmd     (w_pop_cmd),
        .o_out         (o_out)
    );

endmodule

// ===== design/abd_checker.sv =====
// ----------------------------------------------------------------------------
// abd_checker
// Port-level checks of the ADPCM block decoder, bound to the top level.
// ----------------------------------------------------------------------------
module abd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_sample,
    input logic        i_block_last,
    input logic        i_loop_start,
    input logic        i_stop_after,
    input logic        i_loop_repeat
);

    // flag indications only ride on the last sample of a block
    a_flags_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_loop_start || i_stop_after || i_loop_repeat) |-> i_block_last)
        else $error("block flag outside last sample");

    a_stop_repeat_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_stop_after && i_loop_repeat))
        else $error("stop and repeat together");

    // saturation never lets the most negative code through
    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_sample != 16'h8000))
        else $error("sample outside saturation range");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_sample))
        else $error("stalled output item changed");

endmodule

bind adpcm_block_decoder_top abd_checker u_abd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_sample      (o_out.sample),
    .i_block_last  (o_out.block_last),
    .i_loop_start  (o_out.loop_start),
    .i_stop_after  (o_out.stop_after),
    .i_loop_repeat (o_out.loop_repeat)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for adpcm_block_decoder_top. Byte items go in over a
// valid/ready channel and a scoreboard predicts every decoded sample. The
// scoreboard holds its own copy of the block position, header fields and the
// two-sample history. The stimulus has a short directed run first, then
// randomized sounds in phases with different ignore_loop settings. Both sides
// idle at random, and the receiver makes one long hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int BLOCK_BYTES     = 16;
    localparam int LAST_POS        = 1 + abd_pkg::SAMPLES_PER_BLOCK / 2;
    localparam int POS_HEADER      = 0;
    localparam int POS_FLAGS       = 1;
    localparam int FLAG_END_BIT    = 0;
    localparam int FLAG_LOOP_BIT   = 2;
    localparam logic [7:0] FLAGS_REPEAT = 8'h03;
    localparam int SAMPLE_LIMIT    = 32767;
    localparam int IDLE_PCT        = 12;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 40;
    localparam int MAX_PRINTS      = 50;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               block_last;
        logic               loop_start;
        logic               stop_after;
        logic               loop_repeat;
    } t_sample_rec;

    class adpcm_scoreboard;
        bit          ignore_loop;
        logic [3:0]  byte_pos;
        logic [2:0]  filter;
        logic [3:0]  shift;
        logic [7:0]  flags;
        int          hist1;
        int          hist2;
        t_sample_rec pending_samples[$];
        int          errors;

        function new();
            ignore_loop = 1'b0;
            byte_pos    = '0;
            filter      = '0;
            shift       = '0;
            flags       = '0;
            hist1       = 0;
            hist2       = 0;
            errors      = 0;
        endfunction

        function int pending();
            return pending_samples.size();
        endfunction

        function logic signed [15:0] predict_nibble(logic [3:0] nib);
            int tap_a;
            int tap_b;
            int term;
            int acc;
            case (filter)
                3'd0:    begin tap_a = 0;   tap_b = 0;   end
                3'd1:    begin tap_a = 60;  tap_b = 0;   end
                3'd2:    begin tap_a = 115; tap_b = -52; end
                3'd3:    begin tap_a = 98;  tap_b = -55; end
                default: begin tap_a = 122; tap_b = -60; end
            endcase
            // nibble sits in the top four bits of a 16-bit word
            term = $signed({nib, 12'h000});
            term = term >>> shift;
            acc  = term + ((hist1 * tap_a) >>> 6) + ((hist2 * tap_b) >>> 6);
            if (acc > SAMPLE_LIMIT)
                acc = SAMPLE_LIMIT;
            if (acc < -SAMPLE_LIMIT)
                acc = -SAMPLE_LIMIT;
            hist2 = hist1;
            hist1 = acc;
            return acc[15:0];
        endfunction

        function void note_byte(logic [7:0] b, logic rs);
            t_sample_rec r;
            bit          last;
            if (rs) begin
                hist1    = 0;
                hist2    = 0;
                byte_pos = 4'(POS_HEADER);
            end
            if (byte_pos == POS_HEADER) begin
                shift    = b[3:0];
                filter   = (b[7:4] > 4'd4) ? 3'd4 : b[6:4];
                byte_pos = 4'(POS_FLAGS);
            end else if (byte_pos == POS_FLAGS) begin
                flags    = b;
                byte_pos = 4'(POS_FLAGS + 1);
            end else begin
                last   = (byte_pos >= LAST_POS);
                r      = '0;
                r.sample = predict_nibble(b[3:0]);
                pending_samples.push_back(r);
                r.sample      = predict_nibble(b[7:4]);
                r.block_last  = last;
                r.loop_start  = last && flags[FLAG_LOOP_BIT] && !ignore_loop;
                r.stop_after  = last && flags[FLAG_END_BIT] && (flags != FLAGS_REPEAT);
                r.loop_repeat = last && (flags == FLAGS_REPEAT);
                pending_samples.push_back(r);
                byte_pos = last ? 4'(POS_HEADER) : byte_pos + 4'd1;
            end
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTS)
                $display("tb_top: %0t: %s", $time, msg);
            errors++;
        endtask

        task check_sample(t_sample_rec got);
            t_sample_rec e;
            if (pending_samples.size() == 0) begin
                report($sformatf("sample %0d with nothing outstanding", got.sample));
                return;
            end
            e = pending_samples.pop_front();
            if (got.sample !== e.sample || got.block_last !== e.block_last ||
                got.loop_start !== e.loop_start || got.stop_after !== e.stop_after ||
                got.loop_repeat !== e.loop_repeat)
                report($sformatf("got %0d l%b s%b e%b r%b, want %0d l%b s%b e%b r%b",
                    got.sample, got.block_last, got.loop_start, got.stop_after,
                    got.loop_repeat, e.sample, e.block_last, e.loop_start,
                    e.stop_after, e.loop_repeat));
        endtask

        task close();
            if (pending_samples.size() != 0)
                report($sformatf("%0d samples never came out", pending_samples.size()));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    abd_in_if  in_if ();
    abd_out_if out_if ();

    adpcm_block_decoder_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (in_if.sink),
        .o_out         (out_if.source)
    );

    adpcm_scoreboard board = new();
    int in_idle_pct  = IDLE_PCT;
    int out_idle_pct = IDLE_PCT;
    int sent_items   = 0;
    bit hold_req     = 1'b0;

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // accepted items on both channels, sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready)
            board.note_byte(in_if.data_byte, in_if.restart);
    end

    always @(posedge i_clk) begin
        t_sample_rec got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.sample      = out_if.sample;
            got.block_last  = out_if.block_last;
            got.loop_start  = out_if.loop_start;
            got.stop_after  = out_if.stop_after;
            got.loop_repeat = out_if.loop_repeat;
            board.check_sample(got);
        end
    end

    // sample receiver: random stalls plus one long hold-off on request
    initial begin
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            out_if.ready <= ($urandom_range(99) >= out_idle_pct);
            @(posedge i_clk);
        end
    end

    initial begin
        #4000000;
        $display("tb_top: errors");
        $finish;
    end

    task automatic send_item(input logic [7:0] b, input logic rs);
        while ($urandom_range(99) < in_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= b;
        in_if.restart   <= rs;
        do
            @(posedge i_clk);
        while (!in_if.ready);
        sent_items++;
    endtask

    task automatic write_ignore_loop(input bit v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        board.ignore_loop = v;
    endtask

    // stop offering, let every sample come out, then give the block time to settle
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_header();
        logic [3:0] sh;
        logic [3:0] fl;
        sh = ($urandom_range(99) < 75) ? 4'($urandom_range(12)) : 4'($urandom_range(15, 13));
        fl = ($urandom_range(99) < 70) ? 4'($urandom_range(4)) : 4'($urandom_range(15, 5));
        return {fl, sh};
    endfunction

    function automatic logic [7:0] rand_flags();
        if ($urandom_range(99) < 50)
            return 8'($urandom_range(7));
        return 8'($urandom_range(255));
    endfunction

    // one sound of a few blocks; some are cut short and the next restart lands mid-block
    task automatic send_sound();
        int blocks;
        int cut;
        bit broken;
        blocks = $urandom_range(1, 3);
        broken = ($urandom_range(99) < 15);
        cut    = $urandom_range(0, BLOCK_BYTES - 1);
        for (int blk = 0; blk < blocks; blk++) begin
            for (int k = 0; k < BLOCK_BYTES; k++) begin
                if (broken && blk == blocks - 1 && k == cut)
                    return;
                if (k == POS_HEADER)
                    send_item(rand_header(), blk == 0);
                else if (k == POS_FLAGS)
                    send_item(rand_flags(), 1'b0);
                else
                    send_item(8'($urandom_range(255)), 1'b0);
            end
        end
    endtask

    initial begin
        int start;
        i_rst_n         <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_wr_data     <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.data_byte <= '0;
        in_if.restart   <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_ignore_loop(1'b0);

        // filter 0: positive peak, negative peak saturates, all ones
        send_item(8'h00, 1'b1);
        send_item(8'h07, 1'b0);
        send_item(8'h77, 1'b0);
        send_item(8'h88, 1'b0);
        send_item(8'hFF, 1'b0);
        // restart mid-block, oversized filter nibble, positive saturation
        send_item(8'hF0, 1'b1);
        send_item(8'h03, 1'b0);
        send_item(8'h77, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h80, 1'b0);
        // large shifts: 15 leaves only 0 or -1 from the nibble; then 13, 14, 12 and 11
        send_item(8'hDF, 1'b1);
        send_item(8'h04, 1'b0);
        send_item(8'h8F, 1'b0);
        send_item(8'h7F, 1'b0);
        send_item(8'h2D, 1'b1);
        send_item(8'h01, 1'b0);
        send_item(8'hF8, 1'b0);
        send_item(8'h3E, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'h12, 1'b0);
        send_item(8'h1C, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'hA5, 1'b0);
        send_item(8'h5B, 1'b1);
        send_item(8'h02, 1'b0);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            write_ignore_loop(ph % 2 == 0);
            in_idle_pct  = (ph == 2) ? 0 : IDLE_PCT;
            out_idle_pct = (ph == 2) ? 0 : IDLE_PCT;
            if (ph == 3)
                hold_req = 1'b1;
            start = sent_items;
            while (sent_items - start < ITEMS_PER_PHASE)
                send_sound();
            wait_drained();
        end

        board.close();
        if (board.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
